// ===== sv/prls_pkg.sv =====
package prls_pkg;

  localparam int unsigned LabelW   = 16;
  localparam int unsigned CntW     = 25;
  localparam int unsigned SqW      = 33;
  localparam int unsigned PathW    = 25;
  localparam int unsigned TotalW   = 27;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumW     = SqW + FracW;
  localparam int unsigned DenW     = CntW + 1;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned RecipW    = 26;
  localparam int unsigned MeanProdW = TotalW + RecipW;

  localparam logic [CntW-1:0]  CntMax      = '1;
  localparam logic [SqW-1:0]   SqMax       = '1;
  localparam logic [PathW-1:0] PathMax     = '1;
  localparam logic [IdxW-1:0]  LastPass    = IdxW'(2);

  // The product of x and the ceiling of 2^27 / 3, shifted right by 27, is x / 3 rounded down
  // for every x below 2^27.
  localparam logic [RecipW-1:0] MeanRecip = 26'd44739243;

  typedef enum logic [CfgIdxW-1:0] {
    RegTargetLabel = 8'd0,
    RegPathMode    = 8'd1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ModeMembersPerSegment = 1'b0,
    ModeSquaresPerMember  = 1'b1
  } path_mode_e;

  typedef struct packed {
    logic [CntW-1:0] segments;
    logic [CntW-1:0] members;
    logic [SqW-1:0]  squares;
    path_mode_e      mode;
  } pass_sum_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             zero;
    logic [PathW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BkIdle = 4'b0001,
    BkPath = 4'b0010,
    BkMean = 4'b0100,
    BkOut  = 4'b1000
  } back_state_e;

endpackage

// ===== sv/prls_intf.sv =====
interface prls_cell_if;
  logic                           valid;
  logic                           ready;
  logic [prls_pkg::LabelW-1:0]    cell_label;
  logic                           line_end;
  logic                           pass_end;

  modport source (output valid, cell_label, line_end, pass_end, input ready);
  modport sink   (input valid, cell_label, line_end, pass_end, output ready);
endinterface

interface prls_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [prls_pkg::CfgIdxW-1:0]   index;
  logic [prls_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface prls_res_if;
  logic                           valid;
  logic                           ready;
  logic [prls_pkg::IdxW-1:0]      pass_index;
  logic [prls_pkg::CntW-1:0]      segment_count;
  logic [prls_pkg::CntW-1:0]      member_count;
  logic [prls_pkg::SqW-1:0]       square_sum;
  logic [prls_pkg::PathW-1:0]     pass_path;
  logic [prls_pkg::PathW-1:0]     mean_path;
  logic                           zero_denominator;
  logic                           final_pass;

  modport source (output valid, pass_index, segment_count, member_count, square_sum,
                  pass_path, mean_path, zero_denominator, final_pass, input ready);
  modport sink   (input valid, pass_index, segment_count, member_count, square_sum,
                  pass_path, mean_path, zero_denominator, final_pass, output ready);
endinterface

// ===== sv/periodic_run_length_statistics_core.sv =====
// Channel  Direction  Transfer carries
// cell_i   in         cell_label, line_end, pass_end
// cfg_i    in         index (0 target_label, 1 path_mode), data
// res_o    out        per-pass counts, square sum, paths, flags
//
// One cell is taken per cycle while the queue has room; the run tracker and the accumulators
// update in that cycle. A pass result is offered once the pass sum has gone through the
// 25-step restoring divider, with an added mean state on the third pass.
// A zero denominator or a saturated path skips the divider loop.
// A two-entry queue holds finished pass sums, so cells stall only when it is full.
// Reset is asynchronous and active low and clears all control and accumulator state.
module periodic_run_length_statistics_core #(
  parameter int unsigned LINE_MAX = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prls_cell_if.sink  cell_i,
  prls_cfg_if.sink   cfg_i,
  prls_res_if.source res_o
);

  logic                full, push, q_valid, pop;
  prls_pkg::pass_sum_t push_entry, head_entry;
  prls_pkg::div_req_t  div_req;
  prls_pkg::div_rsp_t  div_rsp;

  prls_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  prls_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  prls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  prls_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .entry_i   (head_entry),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .res_o     (res_o)
  );

endmodule

// ===== sv/prls_front.sv =====
module prls_front #(
  parameter int unsigned LINE_MAX = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  prls_cell_if.sink           cell_i,
  prls_cfg_if.sink            cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output prls_pkg::pass_sum_t entry_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam int unsigned PosW = $clog2(LINE_MAX);
  localparam int unsigned SqrW = 2 * LenW;

  logic [prls_pkg::LabelW-1:0] target_q;
  prls_pkg::path_mode_e        mode_q;
  logic [PosW-1:0]             pos_q, pos_d;
  logic [LenW-1:0]             first_q, first_d;
  logic                        fo_q, fo_d;
  logic [LenW-1:0]             cur_q, cur_d;
  logic [prls_pkg::CntW-1:0]   seg_q, seg_d;
  logic [prls_pkg::CntW-1:0]   mem_q, mem_d;
  logic [prls_pkg::SqW-1:0]    sq_q, sq_d;

  logic                        accept, match, fo_eff, close;
  logic [LenW-1:0]             cur_n, first_n, len_a, len_b;
  logic                        fo_n, commit_a, commit_b;
  logic [SqrW-1:0]             sq_a, sq_b;
  logic [prls_pkg::CntW:0]     seg_sum;
  logic [prls_pkg::SqW:0]      sq_sum;
  logic [prls_pkg::CntW-1:0]   seg_n, mem_n;
  logic [prls_pkg::SqW-1:0]    sq_n;

  assign cell_i.ready = !full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = cell_i.valid && cell_i.ready;
  assign match        = (cell_i.cell_label == target_q);
  assign fo_eff       = (pos_q == '0) ? match : fo_q;

  // A run that starts at the line head is held back until the line closes,
  // where it may join the run that touches the line tail.
  always_comb begin
    commit_a = 1'b0;
    len_a    = '0;
    first_n  = first_q;
    if (match) begin
      cur_n = cur_q + LenW'(1);
      fo_n  = fo_eff;
    end else begin
      cur_n = '0;
      fo_n  = 1'b0;
      if (cur_q != '0) begin
        if (fo_eff) begin
          first_n = cur_q;
        end else begin
          commit_a = 1'b1;
          len_a    = cur_q;
        end
      end
    end
  end

  assign close = cell_i.line_end || cell_i.pass_end || (pos_q == PosW'(LINE_MAX - 1));

  always_comb begin
    commit_b = 1'b0;
    len_b    = '0;
    if (close) begin
      if (cur_n != '0) begin
        commit_b = 1'b1;
        len_b    = fo_n ? cur_n : cur_n + first_n;
      end else if (first_n != '0) begin
        commit_b = 1'b1;
        len_b    = first_n;
      end
    end
  end

  assign sq_a    = SqrW'(len_a) * SqrW'(len_a);
  assign sq_b    = SqrW'(len_b) * SqrW'(len_b);
  assign seg_sum = {1'b0, seg_q} + (prls_pkg::CntW + 1)'(commit_a)
                 + (prls_pkg::CntW + 1)'(commit_b);
  assign sq_sum  = {1'b0, sq_q} + (prls_pkg::SqW + 1)'(sq_a) + (prls_pkg::SqW + 1)'(sq_b);
  assign seg_n   = seg_sum[prls_pkg::CntW] ? prls_pkg::CntMax : seg_sum[prls_pkg::CntW-1:0];
  assign sq_n    = sq_sum[prls_pkg::SqW] ? prls_pkg::SqMax : sq_sum[prls_pkg::SqW-1:0];
  assign mem_n   = (match && mem_q != prls_pkg::CntMax) ? mem_q + prls_pkg::CntW'(1) : mem_q;

  assign push_o           = accept && cell_i.pass_end;
  assign entry_o.segments = seg_n;
  assign entry_o.members  = mem_n;
  assign entry_o.squares  = sq_n;
  assign entry_o.mode     = mode_q;

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    fo_d    = fo_q;
    cur_d   = cur_q;
    seg_d   = seg_q;
    mem_d   = mem_q;
    sq_d    = sq_q;
    if (accept) begin
      if (close) begin
        pos_d   = '0;
        first_d = '0;
        fo_d    = 1'b0;
        cur_d   = '0;
      end else begin
        pos_d   = pos_q + PosW'(1);
        first_d = first_n;
        fo_d    = fo_n;
        cur_d   = cur_n;
      end
      if (cell_i.pass_end) begin
        seg_d = '0;
        mem_d = '0;
        sq_d  = '0;
      end else begin
        seg_d = seg_n;
        mem_d = mem_n;
        sq_d  = sq_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mode_q   <= prls_pkg::ModeSquaresPerMember;
      pos_q    <= '0;
      first_q  <= '0;
      fo_q     <= 1'b0;
      cur_q    <= '0;
      seg_q    <= '0;
      mem_q    <= '0;
      sq_q     <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == prls_pkg::RegTargetLabel) begin
          target_q <= cfg_i.data[prls_pkg::LabelW-1:0];
        end else if (cfg_i.index == prls_pkg::RegPathMode) begin
          mode_q <= prls_pkg::path_mode_e'(cfg_i.data[0]);
        end
      end
      pos_q   <= pos_d;
      first_q <= first_d;
      fo_q    <= fo_d;
      cur_q   <= cur_d;
      seg_q   <= seg_d;
      mem_q   <= mem_d;
      sq_q    <= sq_d;
    end
  end

  a_pass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (seg_q == '0 && mem_q == '0 && sq_q == '0))
    else $error("accumulators not cleared after a pass end");

  a_run_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LenW + 1)'(cur_q) <= (LenW + 1)'(pos_q))
    else $error("current run longer than the cells seen in the line");

  a_head_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q != '0 |-> !fo_q)
    else $error("head run stored while still open");

endmodule

// ===== sv/prls_fifo.sv =====
module prls_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  prls_pkg::pass_sum_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output prls_pkg::pass_sum_t entry_o
);

  localparam int unsigned PtrW = $clog2(prls_pkg::QDepth);
  localparam int unsigned CntW = $clog2(prls_pkg::QDepth + 1);

  prls_pkg::pass_sum_t slot_q [prls_pkg::QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(prls_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(prls_pkg::QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(prls_pkg::QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ===== sv/prls_div.sv =====
module prls_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prls_pkg::div_req_t req_i,
  output prls_pkg::div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(prls_pkg::PathW);
  localparam int unsigned DvsW  = prls_pkg::DenW + prls_pkg::PathW - 1;
  localparam int unsigned CmpW  = prls_pkg::DenW + prls_pkg::PathW;

  logic                         busy_q, done_q, zero_q;
  logic [prls_pkg::NumW-1:0]    rem_q;
  logic [DvsW-1:0]              dvs_q;
  logic [prls_pkg::PathW-1:0]   quot_q;
  logic [StepW-1:0]             cnt_q;
  logic                         ge, too_big;

  // The quotient is held to PathW bits: a larger one saturates up front,
  // so the restoring loop needs exactly PathW steps.
  assign too_big = CmpW'(req_i.num) >= {req_i.den, {prls_pkg::PathW{1'b0}}};
  assign ge      = DvsW'(rem_q) >= dvs_q;

  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;
  assign rsp_o.quot = quot_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      dvs_q  <= {req_i.den, {(prls_pkg::PathW - 1){1'b0}}};
      cnt_q  <= StepW'(prls_pkg::PathW - 1);
      zero_q <= (req_i.den == '0);
      if (req_i.den == '0) begin
        quot_q <= '0;
      end else if (too_big) begin
        quot_q <= prls_pkg::PathMax;
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dvs_q[prls_pkg::NumW-1:0];
      end
      quot_q <= {quot_q[prls_pkg::PathW-2:0], ge};
      dvs_q  <= dvs_q >> 1;
      cnt_q  <= cnt_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.den == '0 || too_big) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/prls_back.sv =====
module prls_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  prls_pkg::pass_sum_t entry_i,
  output logic                pop_o,
  output prls_pkg::div_req_t  div_req_o,
  input  prls_pkg::div_rsp_t  div_rsp_i,
  prls_res_if.source          res_o
);

  prls_pkg::back_state_e         state_q, state_d;
  prls_pkg::pass_sum_t           sum_q, sum_d;
  logic [prls_pkg::IdxW-1:0]     pass_q, pass_d;
  logic [prls_pkg::TotalW-1:0]   total_q, total_d;
  logic [prls_pkg::PathW-1:0]    path_q, path_d, mean_q, mean_d;
  logic                          zero_q, zero_d;
  logic                          fin;
  logic [prls_pkg::MeanProdW-1:0] mean_prod;

  assign fin       = (pass_q >= prls_pkg::LastPass);
  assign mean_prod = total_q * prls_pkg::MeanRecip;

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    pass_d    = pass_q;
    total_d   = total_q;
    path_d    = path_q;
    mean_d    = mean_q;
    zero_d    = zero_q;
    pop_o     = 1'b0;
    div_req_o = '0;
    unique case (state_q)
      prls_pkg::BkIdle: begin
        if (valid_i) begin
          pop_o           = 1'b1;
          sum_d           = entry_i;
          div_req_o.start = 1'b1;
          if (entry_i.mode == prls_pkg::ModeMembersPerSegment) begin
            div_req_o.num = prls_pkg::NumW'({entry_i.members, {prls_pkg::FracW{1'b0}}});
            div_req_o.den = prls_pkg::DenW'(entry_i.segments);
          end else begin
            div_req_o.num = {entry_i.squares, {prls_pkg::FracW{1'b0}}};
            div_req_o.den = {entry_i.members, 1'b0};
          end
          state_d = prls_pkg::BkPath;
        end
      end
      prls_pkg::BkPath: begin
        if (div_rsp_i.done) begin
          path_d  = div_rsp_i.quot;
          zero_d  = div_rsp_i.zero;
          total_d = total_q + prls_pkg::TotalW'(div_rsp_i.quot);
          if (fin) begin
            state_d = prls_pkg::BkMean;
          end else begin
            mean_d  = '0;
            state_d = prls_pkg::BkOut;
          end
        end
      end
      prls_pkg::BkMean: begin
        mean_d  = mean_prod[prls_pkg::TotalW +: prls_pkg::PathW];
        state_d = prls_pkg::BkOut;
      end
      prls_pkg::BkOut: begin
        if (res_o.ready) begin
          state_d = prls_pkg::BkIdle;
          if (fin) begin
            pass_d  = '0;
            total_d = '0;
          end else begin
            pass_d = pass_q + prls_pkg::IdxW'(1);
          end
        end
      end
      default: state_d = prls_pkg::BkIdle;
    endcase
  end

  assign res_o.valid            = (state_q == prls_pkg::BkOut);
  assign res_o.pass_index       = pass_q;
  assign res_o.segment_count    = sum_q.segments;
  assign res_o.member_count     = sum_q.members;
  assign res_o.square_sum       = sum_q.squares;
  assign res_o.pass_path        = path_q;
  assign res_o.mean_path        = mean_q;
  assign res_o.zero_denominator = zero_q;
  assign res_o.final_pass       = fin;

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    path_q <= path_d;
    mean_q <= mean_d;
    zero_q <= zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prls_pkg::BkIdle;
      pass_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      total_q <= total_d;
    end
  end

  a_final_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.final_pass |-> res_o.pass_index == prls_pkg::LastPass)
    else $error("final flag on a pass other than the third");

  a_zero_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.zero_denominator |-> res_o.pass_path == '0)
    else $error("nonzero path with a zero denominator");

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && res_o.final_pass |=> pass_q == '0 && total_q == '0)
    else $error("pass counter or path total not cleared after the third pass");

endmodule
